>>> sv/pcc_pkg.sv
// types and constants shared by the curvature pipeline
`default_nettype none
package pcc_pkg;

	localparam int unsigned SQ_STEPS  = 32;
	localparam int unsigned DIV_STEPS = 32;
	localparam int unsigned WIDE      = 128;
	localparam int unsigned DEN_W     = 96;
	localparam int unsigned REM_W     = 36;
	// product, sum, root steps, two multiply stages, quotient steps
	localparam int unsigned NSTAGE    = 2 + SQ_STEPS + 2 + DIV_STEPS;

	typedef struct packed {
		logic        neg;
		logic        zero;
		logic [63:0] mag;
		logic [63:0] s;
	} pcc_side_t;

	typedef struct packed {
		logic             neg;
		logic             zero;
		logic             ovf_hi;
		logic [DEN_W-1:0] den;
	} pcc_dside_t;

endpackage
`default_nettype wire

>>> sv/pcc_if.sv
// sample and result channels
`default_nettype none
interface pcc_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] first_dx;
	logic signed [31:0] second_dx;
	logic signed [31:0] first_dy;
	logic signed [31:0] second_dy;

	modport source (output valid, first_dx, second_dx, first_dy, second_dy, input ready);
	modport sink (input valid, first_dx, second_dx, first_dy, second_dy, output ready);
endinterface

interface pcc_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] kappa;
	logic               zero_speed;
	logic               overflowed;

	modport source (output valid, kappa, zero_speed, overflowed, input ready);
	modport sink (input valid, kappa, zero_speed, overflowed, output ready);
endinterface
`default_nettype wire

>>> sv/pcc_sqrt_cell.sv
// one digit step of the integer square root
`default_nettype none
module pcc_sqrt_cell import pcc_pkg::*; #(
	parameter int unsigned IDX = 0
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire pcc_side_t        side_in,
	input  wire logic [REM_W-1:0] rem_in,
	input  wire logic [31:0]      root_in,
	output pcc_side_t             side_out,
	output logic [REM_W-1:0]      rem_out,
	output logic [31:0]           root_out
);

	logic [REM_W-1:0] remx;
	logic [REM_W-1:0] trial;
	logic [REM_W-1:0] rem_d;
	logic [31:0]      root_d;
	pcc_side_t        side_q;
	logic [REM_W-1:0] rem_q;
	logic [31:0]      root_q;

	always_comb begin
		remx  = {rem_in[REM_W-3:0], side_in.s[2*IDX+1 -: 2]};
		trial = {2'b00, root_in, 2'b01};
		if (remx >= trial) begin
			rem_d  = remx - trial;
			root_d = {root_in[30:0], 1'b1};
		end else begin
			rem_d  = remx;
			root_d = {root_in[30:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= side_in;
			rem_q  <= rem_d;
			root_q <= root_d;
		end
	end

	assign side_out = side_q;
	assign rem_out  = rem_q;
	assign root_out = root_q;

endmodule
`default_nettype wire

>>> sv/pcc_div_cell.sv
// one quotient bit of the restoring divider
`default_nettype none
module pcc_div_cell import pcc_pkg::*; #(
	parameter int unsigned IDX = 0
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire pcc_dside_t       side_in,
	input  wire logic [WIDE-1:0]  rem_in,
	input  wire logic [31:0]      q_in,
	output pcc_dside_t            side_out,
	output logic [WIDE-1:0]       rem_out,
	output logic [31:0]           q_out
);

	logic [WIDE-1:0] shifted;
	logic [WIDE-1:0] rem_d;
	logic [31:0]     q_d;
	pcc_dside_t      side_q;
	logic [WIDE-1:0] rem_q;
	logic [31:0]     q_q;

	always_comb begin
		shifted = {{(WIDE-DEN_W){1'b0}}, side_in.den} << IDX;
		rem_d   = rem_in;
		q_d     = q_in;
		if (rem_in >= shifted) begin
			rem_d    = rem_in - shifted;
			q_d[IDX] = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= side_in;
			rem_q  <= rem_d;
			q_q    <= q_d;
		end
	end

	assign side_out = side_q;
	assign rem_out  = rem_q;
	assign q_out    = q_q;

endmodule
`default_nettype wire

>>> sv/planar_curve_curvature_top.sv
// curvature of a planar curve from its first and second derivatives
// throughput: one sample per cycle while the skid register is empty; products,
// 32 root cells, the wide product and 32 quotient cells are all pipelined, a
// skid register holds one extra item
// reset: arst_n clears the stage valid bits and the output/skid valid flags
`default_nettype none
module planar_curve_curvature_top import pcc_pkg::*; #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	pcc_in_if.sink     sample,
	pcc_out_if.source  result
);

	logic              en;
	logic [NSTAGE-1:0] vld_q;

	logic signed [63:0] p1_s1, p2_s1, xx_s1, yy_s1;
	pcc_side_t          side_s2;

	pcc_side_t          sq_side [SQ_STEPS+1];
	logic [REM_W-1:0]   sq_rem  [SQ_STEPS+1];
	logic [31:0]        sq_root [SQ_STEPS+1];

	pcc_side_t          side_m1;
	logic [63:0]        plo_m1, phi_m1;
	pcc_dside_t         dv_side [DIV_STEPS+1];
	logic [WIDE-1:0]    dv_rem  [DIV_STEPS+1];
	logic [31:0]        dv_q    [DIV_STEPS+1];

	logic [DEN_W-1:0]   den;
	logic [WIDE-1:0]    num;
	pcc_dside_t         dside_m2;
	logic [WIDE-1:0]    rem_m2;

	logic               r_valid;
	logic [31:0]        r_kappa;
	logic               r_zero, r_ovf;
	logic [32:0]        lim;
	logic [31:0]        kval;

	logic               out_v_q, skid_v_q;
	logic [31:0]        out_kappa_q, skid_kappa_q;
	logic               out_zero_q, skid_zero_q, out_ovf_q, skid_ovf_q;

	assign en           = !skid_v_q;
	assign sample.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NSTAGE-2:0], sample.valid};
		end
	end

	// cross products and squares
	always_ff @(posedge clk) begin
		if (en) begin
			p1_s1 <= sample.first_dx * sample.second_dy;
			p2_s1 <= sample.first_dy * sample.second_dx;
			xx_s1 <= sample.first_dx * sample.first_dx;
			yy_s1 <= sample.first_dy * sample.first_dy;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2.neg  <= p1_s1 < p2_s1;
			side_s2.mag  <= (p1_s1 >= p2_s1) ? 64'(p1_s1 - p2_s1) : 64'(p2_s1 - p1_s1);
			side_s2.s    <= 64'(xx_s1) + 64'(yy_s1);
			side_s2.zero <= (64'(xx_s1) + 64'(yy_s1)) == 64'd0;
		end
	end

	assign sq_side[0] = side_s2;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;

	for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
		pcc_sqrt_cell #(.IDX(SQ_STEPS - 1 - j)) u_cell (
			.clk      (clk),
			.en       (en),
			.side_in  (sq_side[j]),
			.rem_in   (sq_rem[j]),
			.root_in  (sq_root[j]),
			.side_out (sq_side[j+1]),
			.rem_out  (sq_rem[j+1]),
			.root_out (sq_root[j+1])
		);
	end

	// speed cubed as s * floor(sqrt(s)), split into two half products
	always_ff @(posedge clk) begin
		if (en) begin
			side_m1 <= sq_side[SQ_STEPS];
			plo_m1  <= 64'(sq_side[SQ_STEPS].s[31:0]) * 64'(sq_root[SQ_STEPS]);
			phi_m1  <= 64'(sq_side[SQ_STEPS].s[63:32]) * 64'(sq_root[SQ_STEPS]);
		end
	end

	assign den = (DEN_W'(phi_m1) << 32) + DEN_W'(plo_m1);
	assign num = {{(WIDE-64){1'b0}}, side_m1.mag} << (2 * FRAC_BITS);

	always_ff @(posedge clk) begin
		if (en) begin
			dside_m2.neg    <= side_m1.neg;
			dside_m2.zero   <= side_m1.zero;
			dside_m2.ovf_hi <= num >= {den, 32'b0};
			dside_m2.den    <= den;
			rem_m2          <= num;
		end
	end

	assign dv_side[0] = dside_m2;
	assign dv_rem[0]  = rem_m2;
	assign dv_q[0]    = '0;

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		pcc_div_cell #(.IDX(DIV_STEPS - 1 - j)) u_cell (
			.clk      (clk),
			.en       (en),
			.side_in  (dv_side[j]),
			.rem_in   (dv_rem[j]),
			.q_in     (dv_q[j]),
			.side_out (dv_side[j+1]),
			.rem_out  (dv_rem[j+1]),
			.q_out    (dv_q[j+1])
		);
	end

	// saturate, apply sign, zero speed wins
	always_comb begin
		lim  = dv_side[DIV_STEPS].neg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
		r_ovf = dv_side[DIV_STEPS].ovf_hi || ({1'b0, dv_q[DIV_STEPS]} > lim);
		kval = r_ovf ? lim[31:0] : dv_q[DIV_STEPS];
		r_kappa = dv_side[DIV_STEPS].neg ? (32'd0 - kval) : kval;
		r_zero = dv_side[DIV_STEPS].zero;
		if (r_zero) begin
			r_kappa = '0;
			r_ovf   = 1'b0;
		end
	end

	assign r_valid = vld_q[NSTAGE-1] && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || result.ready) begin
			out_v_q  <= skid_v_q || r_valid;
			skid_v_q <= 1'b0;
		end else if (r_valid) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || result.ready) begin
			if (skid_v_q) begin
				out_kappa_q <= skid_kappa_q;
				out_zero_q  <= skid_zero_q;
				out_ovf_q   <= skid_ovf_q;
			end else begin
				out_kappa_q <= r_kappa;
				out_zero_q  <= r_zero;
				out_ovf_q   <= r_ovf;
			end
		end else if (r_valid) begin
			skid_kappa_q <= r_kappa;
			skid_zero_q  <= r_zero;
			skid_ovf_q   <= r_ovf;
		end
	end

	assign result.valid      = out_v_q;
	assign result.kappa      = out_kappa_q;
	assign result.zero_speed = out_zero_q;
	assign result.overflowed = out_ovf_q;

`ifndef SYNTHESIS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid item without output item");
	a_zero_speed_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.zero_speed) |-> (result.kappa == 32'd0 && !result.overflowed))
		else $error("zero speed item with nonzero kappa or overflow");
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready) |=> vld_q[0])
		else $error("accepted item missing from first stage");
`endif

endmodule
`default_nettype wire
